[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/pfe_pkg.sv]
// Types, constants and key square helpers for the Playfair encrypt unit.
// No dependencies.
package pfe_pkg;

    localparam int LETTER_W = 5;
    localparam int SIDE     = 5;
    localparam int SQUARE_W = SIDE * SIDE * LETTER_W;

    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [SQUARE_W-1:0] square_t;
    typedef logic [2:0]          coord_t;

    localparam letter_t CODE_X = 5'd23;
    localparam letter_t CODE_J = 5'd9;
    localparam letter_t CODE_I = 5'd8;

    localparam logic [7:0] ASCII_UPPER_A = 8'd65;
    localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
    localparam logic [7:0] ASCII_LOWER_A = 8'd97;
    localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
    localparam logic [6:0] LETTER_BASE   = 7'd65;

    localparam int CFG_DATA_W  = 50;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROWS_UPPER  = 2'd0,
        REG_ROWS_MIDDLE = 2'd1,
        REG_ROW_LOWER   = 2'd2
    } cfg_reg_e;

    localparam logic [49:0] ROWS_UPPER_RST  = 50'd579938304662700;
    localparam logic [49:0] ROWS_MIDDLE_RST = 50'd229809901525689;
    localparam logic [24:0] ROW_LOWER_RST   = 25'd2149955;

    typedef struct packed {
        letter_t first;
        letter_t second;
        logic    last;
        logic    done;
    } pair_t;

    typedef struct packed {
        coord_t row;
        coord_t col;
    } pos_t;

    typedef struct packed {
        logic [6:0] letter;
        logic       last;
        logic       done;
    } out_word_t;

    // Lowest-numbered entry that holds the letter, J searched as I; entry 0 if absent.
    function automatic pos_t locate(square_t sq, letter_t code);
        letter_t key;
        pos_t    pos;
        key = (code == CODE_J) ? CODE_I : code;
        pos = '0;
        for (int r = SIDE - 1; r >= 0; r--) begin
            for (int c = SIDE - 1; c >= 0; c--) begin
                if (sq[(r * SIDE + c) * LETTER_W +: LETTER_W] == key) begin
                    pos.row = coord_t'(r);
                    pos.col = coord_t'(c);
                end
            end
        end
        return pos;
    endfunction

    function automatic letter_t entry_at(square_t sq, pos_t pos);
        letter_t val;
        val = '0;
        for (int r = 0; r < SIDE; r++) begin
            for (int c = 0; c < SIDE; c++) begin
                if (pos.row == coord_t'(r) && pos.col == coord_t'(c)) begin
                    val = sq[(r * SIDE + c) * LETTER_W +: LETTER_W];
                end
            end
        end
        return val;
    endfunction

    function automatic coord_t wrap_inc(coord_t x);
        return (x == coord_t'(SIDE - 1)) ? '0 : x + 3'd1;
    endfunction

endpackage

[rtl/pfe_fifo2w.sv]
// Small register queue: up to two writes and one read per cycle.
// No dependencies.
module pfe_fifo2w #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en0,
    input  logic             wr_en1,
    input  logic [WIDTH-1:0] wr_data0,
    input  logic [WIDTH-1:0] wr_data1,
    output logic             space2,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             not_empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [PW-1:0]    wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PW'(1);
    assign space2       = (count_reg <= CW'(DEPTH - 2));
    assign not_empty    = (count_reg != '0);
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(wr_en0) + PW'(wr_en1);
        rd_ptr_next = rd_ptr_reg + PW'(rd_en);
        count_next  = count_reg + CW'(wr_en0) + CW'(wr_en1) - CW'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en0)
        begin
            mem_reg[wr_ptr_reg] <= wr_data0;
        end
        if (wr_en1)
        begin
            mem_reg[wr_ptr_plus1] <= wr_data1;
        end
    end

endmodule

[rtl/pfe_front.sv]
// Front end: filters and folds bytes, pairs letters into digraphs, pads with X.
// Depends on pfe_pkg.
module pfe_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic          space2,
    input  logic [7:0]    raw_byte,
    input  logic          end_of_message,
    output logic          wr_en0,
    output logic          wr_en1,
    output pfe_pkg::pair_t pair0,
    output pfe_pkg::pair_t pair1
);
    import pfe_pkg::*;

    letter_t pending_letter_reg, pending_letter_next;
    logic    pending_valid_reg, pending_valid_next;

    logic    accept;
    logic    is_upper;
    logic    is_lower;
    logic    is_letter;
    letter_t code;
    logic    has_a;
    logic    has_b;
    pair_t   pair_a;
    pair_t   pair_b;
    letter_t mid_letter;
    logic    mid_valid;

    always_comb
    begin
        accept    = push && space2;
        is_upper  = (raw_byte >= ASCII_UPPER_A) && (raw_byte <= ASCII_UPPER_Z);
        is_lower  = (raw_byte >= ASCII_LOWER_A) && (raw_byte <= ASCII_LOWER_Z);
        is_letter = is_upper || is_lower;
        code      = is_upper ? LETTER_W'(raw_byte - ASCII_UPPER_A)
                             : LETTER_W'(raw_byte - ASCII_LOWER_A);

        has_a      = 1'b0;
        pair_a     = '0;
        mid_letter = pending_letter_reg;
        mid_valid  = pending_valid_reg;
        if (is_letter)
        begin
            if (!pending_valid_reg)
            begin
                mid_letter = code;
                mid_valid  = 1'b1;
            end
            else if (pending_letter_reg == code)
            begin
                // doubled letter: split with X and keep the second one waiting
                has_a         = 1'b1;
                pair_a.first  = pending_letter_reg;
                pair_a.second = CODE_X;
            end
            else
            begin
                has_a         = 1'b1;
                pair_a.first  = pending_letter_reg;
                pair_a.second = code;
                mid_letter    = '0;
                mid_valid     = 1'b0;
            end
        end

        has_b               = end_of_message && mid_valid;
        pair_b              = '0;
        pair_b.first        = mid_letter;
        pair_b.second       = CODE_X;
        pending_letter_next = mid_letter;
        pending_valid_next  = mid_valid;
        if (end_of_message)
        begin
            pending_letter_next = '0;
            pending_valid_next  = 1'b0;
        end

        // flag the last pair of this byte
        if (has_b)
        begin
            pair_b.last = 1'b1;
            pair_b.done = 1'b1;
        end
        else
        begin
            pair_a.last = 1'b1;
            pair_a.done = end_of_message;
        end

        wr_en0 = accept && (has_a || has_b);
        wr_en1 = accept && has_a && has_b;
        pair0  = has_a ? pair_a : pair_b;
        pair1  = pair_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_letter_reg <= '0;
            pending_valid_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pending_letter_reg <= pending_letter_next;
            pending_valid_reg  <= pending_valid_next;
        end
    end

endmodule

[rtl/pfe_back.sv]
// Back end: locates a digraph in the key square, then applies the Playfair rules.
// Depends on pfe_pkg.
module pfe_back (
    input  logic              clk,
    input  logic              rst_n,
    input  pfe_pkg::square_t  square,
    input  logic              pair_valid,
    input  pfe_pkg::pair_t    pair_head,
    output logic              pair_pop,
    input  logic              out_space2,
    output logic              out_wr,
    output pfe_pkg::out_word_t out_word0,
    output pfe_pkg::out_word_t out_word1
);
    import pfe_pkg::*;

    logic s1_valid_reg, s1_valid_next;
    pos_t s1_pos1_reg, s1_pos2_reg;
    logic s1_last_reg, s1_done_reg;

    logic s1_free;
    pos_t e1;
    pos_t e2;

    assign s1_free  = !s1_valid_reg || out_space2;
    assign pair_pop = pair_valid && s1_free;
    assign out_wr   = s1_valid_reg && out_space2;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_free)
        begin
            s1_valid_next = pair_valid;
        end
    end

    always_comb
    begin
        if (s1_pos1_reg.row == s1_pos2_reg.row)
        begin
            e1 = '{row: s1_pos1_reg.row, col: wrap_inc(s1_pos1_reg.col)};
            e2 = '{row: s1_pos2_reg.row, col: wrap_inc(s1_pos2_reg.col)};
        end
        else if (s1_pos1_reg.col == s1_pos2_reg.col)
        begin
            e1 = '{row: wrap_inc(s1_pos1_reg.row), col: s1_pos1_reg.col};
            e2 = '{row: wrap_inc(s1_pos2_reg.row), col: s1_pos2_reg.col};
        end
        else
        begin
            e1 = '{row: s1_pos1_reg.row, col: s1_pos2_reg.col};
            e2 = '{row: s1_pos2_reg.row, col: s1_pos1_reg.col};
        end

        out_word0.letter = LETTER_BASE + 7'(entry_at(square, e1));
        out_word0.last   = 1'b0;
        out_word0.done   = 1'b0;
        out_word1.letter = LETTER_BASE + 7'(entry_at(square, e2));
        out_word1.last   = s1_last_reg;
        out_word1.done   = s1_done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair_pop)
        begin
            s1_pos1_reg <= locate(square, pair_head.first);
            s1_pos2_reg <= locate(square, pair_head.second);
            s1_last_reg <= pair_head.last;
            s1_done_reg <= pair_head.done;
        end
    end

endmodule

[rtl/playfair_stream_encrypt_unit.sv]
// Playfair stream encryptor: front end, digraph queue, cipher back end, result queue.
// Path: digraph queue, back-end locate register, result queue, then the result ports.
// Throughput: one byte per cycle while the digraph queue has two free slots; one letter
// per cycle out of the single-word result port while pop is held.
// Reset (rst_n low, asynchronous): queues empty, no letter pending, default key square.
// Depends on pfe_pkg, pfe_front, pfe_fifo2w, pfe_back and assert_macros.svh.
`include "assert_macros.svh"

module playfair_stream_encrypt_unit #(
    parameter int PAIR_DEPTH = 4,
    parameter int OUT_DEPTH  = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     raw_byte,
    input  logic                           end_of_message,
    output logic                           empty,
    input  logic                           pop,
    output logic [6:0]                     cipher_letter,
    output logic                           last_of_run,
    output logic                           message_done,
    input  logic                           cfg_write,
    input  logic [pfe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pfe_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pfe_pkg::*;

    logic [49:0] rows_upper_reg;
    logic [49:0] rows_middle_reg;
    logic [24:0] row_lower_reg;
    square_t     square;

    logic      pair_wr0, pair_wr1;
    pair_t     pair0, pair1;
    logic      pair_space2;
    logic      pair_pop;
    logic      pair_valid;
    logic [$bits(pair_t)-1:0] pair_rd_data;

    logic      out_wr;
    out_word_t out_word0, out_word1;
    logic      out_space2;
    logic      out_valid;
    logic [$bits(out_word_t)-1:0] out_rd_data;
    out_word_t out_head;

    assign square = {row_lower_reg, rows_middle_reg, rows_upper_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_upper_reg  <= ROWS_UPPER_RST;
            rows_middle_reg <= ROWS_MIDDLE_RST;
            row_lower_reg   <= ROW_LOWER_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_e'(cfg_index))
                REG_ROWS_UPPER:  rows_upper_reg  <= cfg_data;
                REG_ROWS_MIDDLE: rows_middle_reg <= cfg_data;
                REG_ROW_LOWER:   row_lower_reg   <= cfg_data[24:0];
                default:         ;
            endcase
        end
    end

    assign full = !pair_space2;

    pfe_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .space2         (pair_space2),
        .raw_byte       (raw_byte),
        .end_of_message (end_of_message),
        .wr_en0         (pair_wr0),
        .wr_en1         (pair_wr1),
        .pair0          (pair0),
        .pair1          (pair1)
    );

    pfe_fifo2w #(
        .WIDTH ($bits(pair_t)),
        .DEPTH (PAIR_DEPTH)
    ) u_pair_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en0    (pair_wr0),
        .wr_en1    (pair_wr1),
        .wr_data0  (pair0),
        .wr_data1  (pair1),
        .space2    (pair_space2),
        .rd_en     (pair_pop),
        .rd_data   (pair_rd_data),
        .not_empty (pair_valid)
    );

    pfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .square     (square),
        .pair_valid (pair_valid),
        .pair_head  (pair_t'(pair_rd_data)),
        .pair_pop   (pair_pop),
        .out_space2 (out_space2),
        .out_wr     (out_wr),
        .out_word0  (out_word0),
        .out_word1  (out_word1)
    );

    pfe_fifo2w #(
        .WIDTH ($bits(out_word_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en0    (out_wr),
        .wr_en1    (out_wr),
        .wr_data0  (out_word0),
        .wr_data1  (out_word1),
        .space2    (out_space2),
        .rd_en     (pop && out_valid),
        .rd_data   (out_rd_data),
        .not_empty (out_valid)
    );

    assign out_head      = out_word_t'(out_rd_data);
    assign empty         = !out_valid;
    assign cipher_letter = out_head.letter;
    assign last_of_run   = out_head.last;
    assign message_done  = out_head.done;

    `ASSERT_IMPLY(a_done_is_last, !empty && message_done, last_of_run,
        "message end word without end of run")
    `ASSERT_IMPLY(a_letter_range, !empty,
        cipher_letter >= 7'd65 && cipher_letter <= 7'd96, "cipher letter out of range")
    `ASSERT_IMPLY(a_out_room, out_wr, out_space2, "result queue written without room")
    `ASSERT_ALWAYS(a_pair_order, !pair_wr1 || pair_wr0, "second pair write without first")

endmodule

[dv/tb_playfair_stream_encrypt_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for playfair_stream_encrypt_unit: directed table, then random messages
// under several key squares, every cipher word checked against a digraph predictor or a typed row.
// Depends on pfe_pkg and the playfair_stream_encrypt_unit RTL.
module tb_playfair_stream_encrypt_unit;
    import pfe_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 200;
    localparam int RUN_LIMIT_NS  = 2_000_000;
    localparam int DIRECTED_N    = 27;
    localparam logic [6:0] CT_ZERO_KEY = 7'd65;
    localparam logic [6:0] CT_ONES_KEY = 7'd96;

    typedef enum logic [1:0] {
        KEY_RESET,
        KEY_ZERO,
        KEY_ONES
    } key_pick_e;

    typedef struct packed {
        logic [6:0] letter;
        logic       last;
        logic       done;
    } cipher_word_t;

    typedef struct {
        logic [7:0] ch;
        logic       eom;
        key_pick_e  key;
        logic       typed;
        int         words;
        logic [6:0] letter;
    } char_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic [7:0]             raw_byte = 8'd0;
    logic                   end_of_message = 1'b0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [6:0]             cipher_letter;
    logic                   last_of_run;
    logic                   message_done;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Side info that travels with each offered character.
    logic                   row_typed = 1'b0;
    int                     row_count = 0;
    logic [6:0]             row_letter = '0;

    square_t                key_square = {ROW_LOWER_RST, ROWS_MIDDLE_RST, ROWS_UPPER_RST};
    letter_t                held_letter = '0;
    logic                   held_valid = 1'b0;
    cipher_word_t           step_words [4];
    int                     step_count;
    cipher_word_t           pending_cipher [$];
    int                     words_checked = 0;
    int                     n_fail = 0;
    int                     no_gap_run = 0;

    char_row_t directed_rows [DIRECTED_N] = '{
        '{8'h00, 1'b0, KEY_RESET, 1'b0, 0, 7'd0},
        '{"H",   1'b0, KEY_RESET, 1'b0, 0, 7'd0},
        '{8'hFF, 1'b0, KEY_RESET, 1'b0, 0, 7'd0},
        '{"e",   1'b0, KEY_RESET, 1'b0, 0, 7'd0},
        '{"L",   1'b0, KEY_RESET, 1'b0, 0, 7'd0},
        '{"L",   1'b0, KEY_RESET, 1'b0, 0, 7'd0},
        '{"j",   1'b0, KEY_RESET, 1'b0, 0, 7'd0},
        '{"I",   1'b0, KEY_RESET, 1'b0, 0, 7'd0},
        '{"J",   1'b0, KEY_RESET, 1'b0, 0, 7'd0},
        '{"X",   1'b0, KEY_RESET, 1'b0, 0, 7'd0},
        '{"X",   1'b1, KEY_RESET, 1'b0, 0, 7'd0},
        '{".",   1'b1, KEY_RESET, 1'b0, 0, 7'd0},
        '{"a",   1'b1, KEY_RESET, 1'b0, 0, 7'd0},
        '{"z",   1'b0, KEY_RESET, 1'b0, 0, 7'd0},
        '{"@",   1'b0, KEY_RESET, 1'b0, 0, 7'd0},
        '{"[",   1'b0, KEY_RESET, 1'b0, 0, 7'd0},
        '{8'h60, 1'b0, KEY_RESET, 1'b0, 0, 7'd0},
        '{"{",   1'b0, KEY_RESET, 1'b0, 0, 7'd0},
        '{8'h80, 1'b0, KEY_RESET, 1'b0, 0, 7'd0},
        '{"Z",   1'b1, KEY_RESET, 1'b0, 0, 7'd0},
        // all-zero key: every letter lands on entry 0, cipher is always A
        '{"A",   1'b0, KEY_ZERO,  1'b1, 0, CT_ZERO_KEY},
        '{"b",   1'b0, KEY_ZERO,  1'b1, 2, CT_ZERO_KEY},
        '{"C",   1'b0, KEY_ZERO,  1'b1, 0, CT_ZERO_KEY},
        '{"C",   1'b1, KEY_ZERO,  1'b1, 4, CT_ZERO_KEY},
        // all-ones key: no letter found, entry 1 holds code 31
        '{"q",   1'b0, KEY_ONES,  1'b1, 0, CT_ONES_KEY},
        '{"Z",   1'b1, KEY_ONES,  1'b1, 2, CT_ONES_KEY},
        '{"!",   1'b1, KEY_ONES,  1'b1, 0, CT_ONES_KEY}
    };

    playfair_stream_encrypt_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .raw_byte       (raw_byte),
        .end_of_message (end_of_message),
        .empty          (empty),
        .pop            (pop),
        .cipher_letter  (cipher_letter),
        .last_of_run    (last_of_run),
        .message_done   (message_done),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic letter_t square_cell(int k);
        return key_square[k * LETTER_W +: LETTER_W];
    endfunction

    // Lowest entry holding the letter, J searched as I; entry 0 when absent.
    function automatic int find_cell(letter_t code);
        letter_t key;
        key = (code == CODE_J) ? CODE_I : code;
        for (int k = 0; k < SIDE * SIDE; k++)
        begin
            if (square_cell(k) == key)
                return k;
        end
        return 0;
    endfunction

    function automatic void encipher_digraph(letter_t a, letter_t b);
        int p1;
        int p2;
        int e1;
        int e2;
        p1 = find_cell(a);
        p2 = find_cell(b);
        if (p1 / SIDE == p2 / SIDE)
        begin
            e1 = (p1 / SIDE) * SIDE + (p1 % SIDE + 1) % SIDE;
            e2 = (p2 / SIDE) * SIDE + (p2 % SIDE + 1) % SIDE;
        end
        else if (p1 % SIDE == p2 % SIDE)
        begin
            e1 = ((p1 / SIDE + 1) % SIDE) * SIDE + p1 % SIDE;
            e2 = ((p2 / SIDE + 1) % SIDE) * SIDE + p2 % SIDE;
        end
        else
        begin
            e1 = (p1 / SIDE) * SIDE + p2 % SIDE;
            e2 = (p2 / SIDE) * SIDE + p1 % SIDE;
        end
        step_words[step_count]     = '{LETTER_BASE + {2'b00, square_cell(e1)}, 1'b0, 1'b0};
        step_words[step_count + 1] = '{LETTER_BASE + {2'b00, square_cell(e2)}, 1'b0, 1'b0};
        step_count += 2;
    endfunction

    function automatic void encipher_char(logic [7:0] ch, logic eom);
        logic    is_alpha;
        letter_t code;
        step_count = 0;
        is_alpha = 1'b0;
        code = '0;
        if (ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_Z)
        begin
            is_alpha = 1'b1;
            code = letter_t'(ch - ASCII_UPPER_A);
        end
        else if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z)
        begin
            is_alpha = 1'b1;
            code = letter_t'(ch - ASCII_LOWER_A);
        end
        if (is_alpha)
        begin
            if (!held_valid)
            begin
                held_letter = code;
                held_valid = 1'b1;
            end
            else if (held_letter == code)
            begin
                // doubled letter: pad with X, keep the second one held
                encipher_digraph(held_letter, CODE_X);
            end
            else
            begin
                encipher_digraph(held_letter, code);
                held_valid = 1'b0;
                held_letter = '0;
            end
        end
        if (eom)
        begin
            if (held_valid)
                encipher_digraph(held_letter, CODE_X);
            held_valid = 1'b0;
            held_letter = '0;
            if (step_count > 0)
                step_words[step_count - 1].done = 1'b1;
        end
        if (step_count > 0)
            step_words[step_count - 1].last = 1'b1;
    endfunction

    // Check popped words first; a word accepted now cannot show up at this same edge.
    always @(posedge clk)
    begin : check_words
        cipher_word_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                words_checked++;
                if (pending_cipher.size() == 0)
                begin
                    $error("cipher word with none expected: cipher_letter %0d", cipher_letter);
                    n_fail++;
                end
                else
                begin
                    want = pending_cipher.pop_front();
                    if (cipher_letter !== want.letter)
                    begin
                        $error("cipher_letter: expected %0d, got %0d", want.letter, cipher_letter);
                        n_fail++;
                    end
                    if (last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
                        n_fail++;
                    end
                    if (message_done !== want.done)
                    begin
                        $error("message_done: expected %0b, got %0b", want.done, message_done);
                        n_fail++;
                    end
                end
            end
            if (push && !full)
            begin
                encipher_char(raw_byte, end_of_message);
                if (row_typed)
                begin
                    for (int i = 0; i < row_count; i++)
                        pending_cipher.push_back('{row_letter, i == row_count - 1,
                                                   end_of_message && i == row_count - 1});
                end
                else
                begin
                    for (int i = 0; i < step_count; i++)
                        pending_cipher.push_back(step_words[i]);
                end
            end
        end
    end

    // Result side: random pop stretches, plus a long hold now and then to back up the input.
    initial
    begin : result_side
        int r;
        int len;
        int hold_mark;
        hold_mark = 30;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (words_checked >= hold_mark)
            begin
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_mark += 90;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    pop <= 1'b1;
                    len = $urandom_range(1, 20);
                end
                else if (r < 90)
                begin
                    pop <= 1'b0;
                    len = $urandom_range(1, 3);
                end
                else
                begin
                    pop <= 1'b0;
                    len = $urandom_range(10, 40);
                end
                repeat (len) @(posedge clk);
            end
        end
    end

    task automatic offer_char(input logic [7:0] ch, input logic eom, input logic typed,
                              input int n, input logic [6:0] letter);
        raw_byte       <= ch;
        end_of_message <= eom;
        row_typed      <= typed;
        row_count      <= n;
        row_letter     <= letter;
        push           <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic sender_pause();
        int r;
        int len;
        len = 0;
        r = $urandom_range(0, 99);
        if (no_gap_run > 0)
            no_gap_run--;
        else if (r < 8)
            no_gap_run = $urandom_range(10, 25);
        else if (r < 55)
            len = 0;
        else if (r < 90)
            len = $urandom_range(1, 3);
        else
            len = $urandom_range(8, 30);
        if (len > 0)
        begin
            push <= 1'b0;
            repeat (len) @(posedge clk);
        end
    endtask

    // Hold input off until every expected word is out, then let the pipeline settle.
    task automatic drain_block();
        push <= 1'b0;
        @(posedge clk);
        while (pending_cipher.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_key(input square_t sq);
        cfg_write <= 1'b1;
        cfg_index <= REG_ROWS_UPPER;
        cfg_data  <= sq[49:0];
        @(posedge clk);
        cfg_index <= REG_ROWS_MIDDLE;
        cfg_data  <= sq[99:50];
        @(posedge clk);
        cfg_index <= REG_ROW_LOWER;
        cfg_data  <= {25'd0, sq[124:100]};
        @(posedge clk);
        cfg_write <= 1'b0;
        key_square = sq;
    endtask

    // Proper Playfair key: the 25 letters without J in random order.
    function automatic square_t shuffled_key();
        letter_t codes [25];
        letter_t t;
        square_t sq;
        int      n;
        int      j;
        n = 0;
        for (int c = 0; c < 26; c++)
        begin
            if (letter_t'(c) != CODE_J)
            begin
                codes[n] = letter_t'(c);
                n++;
            end
        end
        for (int i = 24; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = codes[i];
            codes[i] = codes[j];
            codes[j] = t;
        end
        for (int k = 0; k < 25; k++)
            sq[k * LETTER_W +: LETTER_W] = codes[k];
        return sq;
    endfunction

    // Any 5-bit codes: duplicates, missing letters and non-letter entries.
    function automatic square_t garbage_key();
        square_t sq;
        for (int k = 0; k < 25; k++)
            sq[k * LETTER_W +: LETTER_W] = letter_t'($urandom_range(0, 31));
        return sq;
    endfunction

    function automatic logic [7:0] pick_char(logic [7:0] prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 8'($urandom_range(0, 255));
        if (r < 20)
        begin
            case ($urandom_range(0, 5))
                0: return "J";
                1: return "I";
                2: return "X";
                3: return "j";
                4: return "i";
                default: return "x";
            endcase
        end
        if (r < 38)
            return $urandom_range(0, 1) ? (prev ^ 8'h20) : prev;
        return 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? ASCII_LOWER_A : ASCII_UPPER_A);
    endfunction

    task automatic send_messages(input int letters_goal);
        int         letters;
        int         len;
        logic [7:0] ch;
        logic [7:0] prev;
        letters = 0;
        prev = ASCII_UPPER_A;
        while (letters < letters_goal)
        begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                ch = pick_char(prev);
                if ((ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_Z) ||
                    (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z))
                begin
                    prev = ch;
                    letters++;
                end
                offer_char(ch, i == len - 1, 1'b0, 0, 7'd0);
                sender_pause();
            end
        end
    endtask

    initial
    begin : stimulus
        key_pick_e cur_key;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_key = KEY_RESET;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].key != cur_key)
            begin
                cur_key = directed_rows[i].key;
                drain_block();
                load_key(cur_key == KEY_ZERO ? square_t'('0) : square_t'('1));
            end
            offer_char(directed_rows[i].ch, directed_rows[i].eom, directed_rows[i].typed,
                       directed_rows[i].words, directed_rows[i].letter);
            sender_pause();
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            drain_block();
            load_key(phase == 1 || phase == 3 ? garbage_key() : shuffled_key());
            send_messages(20);
        end

        drain_block();
        if (n_fail == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/pfe_pkg.sv
rtl/pfe_fifo2w.sv
rtl/pfe_front.sv
rtl/pfe_back.sv
rtl/playfair_stream_encrypt_unit.sv
dv/tb_playfair_stream_encrypt_unit.sv
